/* rtl/rmvs_pkg.sv */
package rmvs_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int COUNT_WIDTH  = 32;

  localparam int OUT_W   = 32;
  localparam int M2_W    = 64;
  localparam int FRAC_W  = 16;

  // difference width, multiplier half width, product width
  localparam int DIFF_W  = SAMPLE_WIDTH + 1;
  localparam int HALF_W  = (DIFF_W + 1) / 2;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int INC_W   = PROD_W - FRAC_W;
  localparam int DIV_CNT_W = $clog2(DIFF_W + 1);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic        [COUNT_WIDTH-1:0]  count_t;
  typedef logic signed [DIFF_W-1:0]       diff_t;
  typedef logic        [DIFF_W-1:0]       mag_t;
  typedef logic        [PROD_W-1:0]       prod_t;
  typedef logic        [M2_W-1:0]         m2_t;

  localparam sample_t SAMPLE_MAXV = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t SAMPLE_MINV = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic   start;
    mag_t   dividend;
    count_t divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    mag_t quotient;
  } div_rsp_t;

  typedef struct packed {
    logic start;
    mag_t op_a;
    mag_t op_b;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    prod_t product;
  } mul_rsp_t;

endpackage

/* rtl/rmvs_ifs.sv */
interface rmvs_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;
  logic               restart;

  modport source(output valid, sample, restart, input ready);
  modport sink(input valid, sample, restart, output ready);
endinterface

interface rmvs_out_if;
  logic               valid;
  logic               ready;
  logic        [31:0] sample_count;
  logic signed [31:0] mean_value;
  logic        [63:0] squared_deviation_sum;
  logic signed [31:0] largest_value;
  logic signed [31:0] smallest_value;

  modport source(output valid, sample_count, mean_value, squared_deviation_sum,
                 largest_value, smallest_value, input ready);
  modport sink(input valid, sample_count, mean_value, squared_deviation_sum,
               largest_value, smallest_value, output ready);
endinterface

/* rtl/rmvs_div.sv */
module rmvs_div (
  input  logic               clk,
  input  logic               rst_n,
  input  rmvs_pkg::div_req_t req,
  output rmvs_pkg::div_rsp_t rsp
);

  logic                                       busy_r;
  logic                                       done_r;
  logic [rmvs_pkg::DIV_CNT_W-1:0]             cnt_r;
  rmvs_pkg::count_t                           rem_r;
  rmvs_pkg::count_t                           dvsr_r;
  rmvs_pkg::mag_t                             quo_r;
  logic [rmvs_pkg::COUNT_WIDTH:0]             trial;
  logic [rmvs_pkg::COUNT_WIDTH:0]             diff;

  // restoring step, one quotient bit a cycle
  assign trial = {rem_r, quo_r[rmvs_pkg::DIFF_W-1]};
  assign diff  = trial - {1'b0, dvsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= rmvs_pkg::DIV_CNT_W'(rmvs_pkg::DIFF_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == rmvs_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= '0;
      quo_r  <= req.dividend;
      dvsr_r <= req.divisor;
    end else if (busy_r) begin
      if (!diff[rmvs_pkg::COUNT_WIDTH]) begin
        rem_r <= diff[rmvs_pkg::COUNT_WIDTH-1:0];
        quo_r <= {quo_r[rmvs_pkg::DIFF_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[rmvs_pkg::COUNT_WIDTH-1:0];
        quo_r <= {quo_r[rmvs_pkg::DIFF_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

/* rtl/rmvs_mul.sv */
module rmvs_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  rmvs_pkg::mul_req_t req,
  output rmvs_pkg::mul_rsp_t rsp
);

  localparam int HW = rmvs_pkg::HALF_W;

  logic                 busy_r;
  logic                 done_r;
  logic [2:0]           ph_r;
  logic                 pv_r;
  logic [1:0]           psh_r;
  logic [2*HW-1:0]      a_r;
  logic [2*HW-1:0]      b_r;
  logic [2*HW-1:0]      pp_r;
  rmvs_pkg::prod_t      acc_r;
  logic [HW-1:0]        opa;
  logic [HW-1:0]        opb;
  logic [1:0]           sh;
  logic [4*HW-1:0]      pp_sh;

  // partial product select: lo*lo, lo*hi, hi*lo, hi*hi
  always_comb begin
    unique case (ph_r[1:0])
      2'd0: begin opa = a_r[HW-1:0];    opb = b_r[HW-1:0];    sh = 2'd0; end
      2'd1: begin opa = a_r[HW-1:0];    opb = b_r[2*HW-1:HW]; sh = 2'd1; end
      2'd2: begin opa = a_r[2*HW-1:HW]; opb = b_r[HW-1:0];    sh = 2'd1; end
      default: begin opa = a_r[2*HW-1:HW]; opb = b_r[2*HW-1:HW]; sh = 2'd2; end
    endcase
  end

  always_comb begin
    unique case (psh_r)
      2'd0:    pp_sh = (4*HW)'(pp_r);
      2'd1:    pp_sh = (4*HW)'(pp_r) << HW;
      default: pp_sh = (4*HW)'(pp_r) << (2*HW);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= '0;
      pv_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        ph_r   <= '0;
        pv_r   <= 1'b0;
      end else if (busy_r) begin
        if (ph_r != 3'd4) begin
          ph_r <= ph_r + 1'b1;
          pv_r <= 1'b1;
        end else begin
          pv_r   <= 1'b0;
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= (2*HW)'(req.op_a);
      b_r   <= (2*HW)'(req.op_b);
      acc_r <= '0;
    end else if (busy_r) begin
      if (ph_r != 3'd4) begin
        pp_r  <= opa * opb;
        psh_r <= sh;
      end
      if (pv_r) begin
        acc_r <= acc_r + pp_sh[rmvs_pkg::PROD_W-1:0];
      end
    end
  end

  assign rsp.done    = done_r;
  assign rsp.product = acc_r;

endmodule

/* rtl/running_mean_variance_stats.sv */
// One word at a time: the input is ready only while idle, so a word is taken only after the
//   previous one has been through the bit-serial divider (one quotient bit a cycle), a
//   four-pass half-width multiplier and the output register load.
// A finished result waits in the output register while the next word is accepted.
// Reset (synchronous, rst_n low): count, mean and M2 to zero, max to the most
//   negative value, min to the most positive value, output empty.
module running_mean_variance_stats (
  input  logic             clk,
  input  logic             rst_n,
  rmvs_in_if.sink          in_ch,
  rmvs_out_if.source       out_ch
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DELTA = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MEAN  = 3'd3;
  localparam logic [2:0] S_D2    = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_M2    = 3'd6;
  localparam logic [2:0] S_PUSH  = 3'd7;

  localparam int SW = rmvs_pkg::SAMPLE_WIDTH;
  localparam int DW = rmvs_pkg::DIFF_W;

  logic [2:0]          state_r;
  logic [2:0]          state_nxt;

  rmvs_pkg::count_t    count_r;
  rmvs_pkg::sample_t   mean_r;
  rmvs_pkg::m2_t       m2_r;
  rmvs_pkg::sample_t   max_r;
  rmvs_pkg::sample_t   min_r;

  rmvs_pkg::sample_t   x_r;
  rmvs_pkg::mag_t      dmag_r;
  logic                dneg_r;
  logic                dnz_r;
  logic                neg_r;

  logic                out_valid_r;
  logic [31:0]         out_count_r;
  logic signed [31:0]  out_mean_r;
  logic [63:0]         out_m2_r;
  logic signed [31:0]  out_max_r;
  logic signed [31:0]  out_min_r;

  logic                accept;
  logic                load_out;
  rmvs_pkg::sample_t   x_in;
  rmvs_pkg::count_t    cnt_base;
  rmvs_pkg::sample_t   max_base;
  rmvs_pkg::sample_t   min_base;

  rmvs_pkg::diff_t     sub_res;
  rmvs_pkg::mag_t      sub_mag;
  logic signed [DW:0]  q_s;
  logic signed [DW:0]  mean_sum;
  logic [rmvs_pkg::INC_W-1:0] inc;
  logic [rmvs_pkg::M2_W:0]    m2_add;
  logic [rmvs_pkg::M2_W:0]    m2_sub;

  rmvs_pkg::div_req_t  div_req;
  rmvs_pkg::div_rsp_t  div_rsp;
  rmvs_pkg::mul_req_t  mul_req;
  rmvs_pkg::mul_rsp_t  mul_rsp;

  rmvs_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));
  rmvs_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign load_out    = (state_r == S_PUSH) && (!out_valid_r || out_ch.ready);

  assign x_in     = rmvs_pkg::sample_t'(in_ch.sample[SW-1:0]);
  assign cnt_base = in_ch.restart ? '0 : count_r;
  assign max_base = in_ch.restart ? rmvs_pkg::SAMPLE_MINV : max_r;
  assign min_base = in_ch.restart ? rmvs_pkg::SAMPLE_MAXV : min_r;

  // shared subtractor: delta before the mean update, second delta after it
  assign sub_res = rmvs_pkg::diff_t'(x_r) - rmvs_pkg::diff_t'(mean_r);
  assign sub_mag = sub_res[DW-1] ? rmvs_pkg::mag_t'(-sub_res) : rmvs_pkg::mag_t'(sub_res);

  assign q_s      = $signed({1'b0, div_rsp.quotient});
  assign mean_sum = (DW+1)'(mean_r) + (dneg_r ? -q_s : q_s);

  assign inc    = mul_rsp.product[rmvs_pkg::PROD_W-1:rmvs_pkg::FRAC_W];
  assign m2_add = {1'b0, m2_r} + (rmvs_pkg::M2_W+1)'(inc);
  assign m2_sub = {1'b0, m2_r} - (rmvs_pkg::M2_W+1)'(inc);

  assign div_req.start    = (state_r == S_DELTA);
  assign div_req.dividend = sub_mag;
  assign div_req.divisor  = count_r;

  assign mul_req.start = (state_r == S_D2);
  assign mul_req.op_a  = dmag_r;
  assign mul_req.op_b  = sub_mag;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_DELTA;
      S_DELTA: state_nxt = S_DIV;
      S_DIV:   if (div_rsp.done) state_nxt = S_MEAN;
      S_MEAN:  state_nxt = S_D2;
      S_D2:    state_nxt = S_MUL;
      S_MUL:   if (mul_rsp.done) state_nxt = S_M2;
      S_M2:    state_nxt = S_PUSH;
      S_PUSH:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      mean_r  <= '0;
      m2_r    <= '0;
      max_r   <= rmvs_pkg::SAMPLE_MINV;
      min_r   <= rmvs_pkg::SAMPLE_MAXV;
    end else begin
      if (accept) begin
        count_r <= (cnt_base == '1) ? cnt_base : cnt_base + 1'b1;
        if (in_ch.restart) begin
          mean_r <= '0;
          m2_r   <= '0;
        end
        max_r <= (x_in > max_base) ? x_in : max_base;
        min_r <= (x_in < min_base) ? x_in : min_base;
      end
      if (state_r == S_MEAN) begin
        mean_r <= mean_sum[SW-1:0];
      end
      if (state_r == S_M2) begin
        if (neg_r) begin
          m2_r <= m2_sub[rmvs_pkg::M2_W] ? '0 : m2_sub[rmvs_pkg::M2_W-1:0];
        end else begin
          m2_r <= m2_add[rmvs_pkg::M2_W] ? '1 : m2_add[rmvs_pkg::M2_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= x_in;
    end
    if (state_r == S_DELTA) begin
      dmag_r <= sub_mag;
      dneg_r <= sub_res[DW-1];
      dnz_r  <= (sub_res != '0);
    end
    if (state_r == S_D2) begin
      neg_r <= (dneg_r != sub_res[DW-1]) && dnz_r && (sub_res != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_count_r <= rmvs_pkg::OUT_W'(count_r);
      out_mean_r  <= rmvs_pkg::OUT_W'(mean_r);
      out_m2_r    <= m2_r;
      out_max_r   <= rmvs_pkg::OUT_W'(max_r);
      out_min_r   <= rmvs_pkg::OUT_W'(min_r);
    end
  end

  assign out_ch.valid                 = out_valid_r;
  assign out_ch.sample_count          = out_count_r;
  assign out_ch.mean_value            = out_mean_r;
  assign out_ch.squared_deviation_sum = out_m2_r;
  assign out_ch.largest_value         = out_max_r;
  assign out_ch.smallest_value        = out_min_r;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIV)
    else $error("divider finished outside its step");

  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> state_r == S_MUL)
    else $error("multiplier finished outside its step");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && count_r != '0) |-> min_r <= max_r)
    else $error("min above max");

  a_mean_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && count_r != '0) |-> (mean_r >= min_r && mean_r <= max_r))
    else $error("mean outside sample range");

  a_load_after_m2: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_M2) |=> state_r == S_PUSH)
    else $error("M2 update not followed by result");

endmodule

/* tb/rmvs_stats_checker.sv */
module rmvs_stats_checker
  import rmvs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  rmvs_in_if   in_mon,
  rmvs_out_if  out_mon,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    count_t  sample_count;
    sample_t mean_value;
    m2_t     sqdev_sum;
    sample_t largest;
    sample_t smallest;
  } stats_t;

  count_t  tally;
  sample_t run_mean;
  m2_t     run_m2;
  sample_t run_max;
  sample_t run_min;

  stats_t expected_stats[$];
  stats_t want;
  int     errs;

  function automatic void clear_stats();
    tally    = '0;
    run_mean = '0;
    run_m2   = '0;
    run_max  = SAMPLE_MINV;
    run_min  = SAMPLE_MAXV;
  endfunction

  // one Welford step on the local copy of the statistics
  function automatic stats_t welford_update(sample_t x, logic restart);
    longint dev_old;
    longint dev_new;
    m2_t    mag_old;
    m2_t    mag_new;
    m2_t    step;
    stats_t r;
    if (restart) clear_stats();
    if (tally != {COUNT_WIDTH{1'b1}}) tally = tally + 1'b1;
    dev_old  = longint'(x) - longint'(run_mean);
    run_mean = sample_t'(longint'(run_mean) + dev_old / longint'(tally));
    dev_new  = longint'(x) - longint'(run_mean);
    mag_old  = m2_t'(dev_old < 0 ? -dev_old : dev_old);
    mag_new  = m2_t'(dev_new < 0 ? -dev_new : dev_new);
    step     = (mag_old * mag_new) >> FRAC_W;
    if ((dev_old < 0) != (dev_new < 0) && dev_old != 0 && dev_new != 0) begin
      run_m2 = (step > run_m2) ? '0 : run_m2 - step;
    end else if (run_m2 > ~step) begin
      run_m2 = '1;
    end else begin
      run_m2 = run_m2 + step;
    end
    if (x > run_max) run_max = x;
    if (x < run_min) run_min = x;
    r.sample_count = tally;
    r.mean_value   = run_mean;
    r.sqdev_sum    = run_m2;
    r.largest      = run_max;
    r.smallest     = run_min;
    return r;
  endfunction

  function automatic int field_diff(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v === act_v) return 0;
    $error("%s mismatch: expected 0x%h, got 0x%h", name, exp_v, act_v);
    return 1;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_stats();
      expected_stats.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      errs = 0;
      if (in_mon.valid && in_mon.ready)
        expected_stats.push_back(welford_update(sample_t'(in_mon.sample), in_mon.restart));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_stats.size() == 0) begin
          $error("result word with nothing outstanding");
          errs = 1;
        end else begin
          want = expected_stats.pop_front();
          errs = field_diff("sample_count", want.sample_count, out_mon.sample_count)
               + field_diff("mean_value", want.mean_value, out_mon.mean_value)
               + field_diff("squared_deviation_sum", want.sqdev_sum,
                            out_mon.squared_deviation_sum)
               + field_diff("largest_value", want.largest, out_mon.largest_value)
               + field_diff("smallest_value", want.smallest, out_mon.smallest_value);
        end
      end
      pending    <= expected_stats.size();
      fail_count <= fail_count + errs;
    end
  end

endmodule

/* tb/tb.sv */
module tb;
  import rmvs_pkg::*;

  localparam int RANDOM_WORDS = 1430;
  localparam int STALL_LIMIT  = 4000;

  logic clk;
  logic rst_n;
  logic steady;
  int   fail_count;
  int   pending;
  int   words_sent;
  int   restarts_sent;
  int   results_seen;
  int   stall_cycles;
  int   i;
  logic rs;
  sample_t centre;

  sample_t dir_sample[20] = '{
    32'sh0000_0000, 32'sh0000_0000, SAMPLE_MAXV, SAMPLE_MINV, SAMPLE_MAXV,
    SAMPLE_MINV, -32'sd1, 32'sd1, 32'sh0001_0000, SAMPLE_MAXV,
    SAMPLE_MINV, -32'sh0001_0000, -32'sh0001_0000, 32'sh8000_0001, 32'sh7FFF_FFFE,
    SAMPLE_MINV, SAMPLE_MINV, SAMPLE_MAXV, SAMPLE_MAXV, 32'sh5555_AAAA
  };
  logic dir_restart[20] = '{
    1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1
  };

  rmvs_in_if  in_ch();
  rmvs_out_if out_ch();

  running_mean_variance_stats uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rmvs_stats_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk <= 1'b0;
    #6;
    clk <= 1'b1;
    #6;
  end

  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= 35);
  end

  always @(posedge clk) begin
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", stall_cycles);
      $display("running_mean_variance_stats regression: fail");
      $finish;
    end
    if (!rst_n)
      results_seen <= 0;
    else if (out_ch.valid && out_ch.ready)
      results_seen <= results_seen + 1;
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  task automatic send_word(input sample_t s, input logic restart);
    if (!steady && $urandom_range(99) < 35) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 35);
    end
    in_ch.valid   <= 1'b1;
    in_ch.sample  <= s;
    in_ch.restart <= restart;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    if (restart) restarts_sent++;
  endtask

  // hold the input off until every outstanding result has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic sample_t pick_sample();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) return sample_t'($urandom);
    if (roll < 75) return centre + sample_t'(int'($urandom_range(2097150)) - 1048575);
    if (roll < 85) begin
      case ($urandom_range(3))
        0:       return SAMPLE_MAXV;
        1:       return SAMPLE_MINV;
        2:       return '0;
        default: return -32'sd1;
      endcase
    end
    // within +/-100.0
    return sample_t'(int'($urandom_range(13107200)) - 6553600);
  endfunction

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.sample  <= '0;
    in_ch.restart <= 1'b0;
    rst_n         <= 1'b0;
    steady         = 1'b0;
    words_sent     = 0;
    restarts_sent  = 0;
    centre         = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < 20; i++) send_word(dir_sample[i], dir_restart[i]);
    drain();

    for (i = 0; i < RANDOM_WORDS; i++) begin
      steady = (i >= 500 && i < 700);
      if (i == 300 || i == 1000) drain();
      rs = ($urandom_range(99) < 3);
      if (rs) centre = sample_t'($signed($urandom) >>> 1);
      send_word(pick_sample(), rs);
    end
    steady = 1'b0;

    drain();
    repeat (60) @(posedge clk);

    $display("%0d samples driven, %0d restarting the accumulation; %0d results compared",
             words_sent, restarts_sent, results_seen);
    $display("covered full-scale swings, ties at both extremes, clustered and small values");
    if (fail_count == 0) begin
      $display("running_mean_variance_stats regression: pass");
    end else begin
      $display("running_mean_variance_stats regression: fail");
    end
    $finish;
  end

endmodule
